@@ src/lfu_pkg.sv @@
// ---------------------------------------------------------------------------
// lfu_pkg
// Shared types and codes for the LFU cache put engine.
// ---------------------------------------------------------------------------
package lfu_pkg;

    localparam logic [1:0] OUT_HIT    = 2'd0;
    localparam logic [1:0] OUT_FREE   = 2'd1;
    localparam logic [1:0] OUT_EVICT  = 2'd2;
    localparam logic [1:0] OUT_IGNORE = 2'd3;

    localparam int          CAP_W     = 5;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_UPDATE = 4'b1000
    } t_state;

endpackage

@@ src/lfu_cache_put.sv @@
// ---------------------------------------------------------------------------
// lfu_cache_put
// Put path of a least-frequently-used cache with oldest-first tie break.
// ---------------------------------------------------------------------------
// A put is taken when i_start is high and o_busy is low. The slots live in a
// single-read-port memory that one compare unit walks a slot per cycle to find
// the key, the first free slot and the victim (lowest count, then oldest
// stamp). A put runs from transfer to result through the transfer, a memory
// read of every slot, the last compare and a write-back; the next put is
// taken in the cycle the result shows. With capacity zero the put is ignored
// and its result shows the next cycle, o_busy staying low. Results are strobed
// by o_result_valid for exactly one cycle and cannot be held off. The store is
// cleared by reset through the per-slot valid bits, so no clearing pass is
// needed.
// ---------------------------------------------------------------------------
module lfu_cache_put #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic signed [31:0]       i_req_key,
    input  logic signed [31:0]       i_req_value,
    output logic                     o_result_valid,
    output logic        [1:0]        o_outcome,
    output logic signed [31:0]       o_evicted_key,
    output logic        [15:0]       o_use_count,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic        [lfu_pkg::CAP_W-1:0] i_cfg_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(ENTRIES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // slot memories
    logic [31:0]           mem_key   [ENTRIES];
    logic [31:0]           mem_value [ENTRIES];
    logic [COUNT_BITS-1:0] mem_count [ENTRIES];
    logic [31:0]           mem_stamp [ENTRIES];

    lfu_pkg::t_state r_state, n_state;

    logic [lfu_pkg::CAP_W-1:0] r_cap;
    logic [ENTRIES-1:0]        r_valid;
    logic [OCC_W-1:0]          r_occupied;
    logic [31:0]               r_clock;

    logic [31:0]      r_req_key;
    logic [31:0]      r_req_value;
    logic [IDX_W-1:0] r_addr;

    // read pipeline
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx;
    logic                  r_rd_valid;
    logic [31:0]           r_rd_key;
    logic [COUNT_BITS-1:0] r_rd_count;
    logic [31:0]           r_rd_stamp;

    // scan trackers
    logic                  r_h_found;
    logic [IDX_W-1:0]      r_h_idx;
    logic [COUNT_BITS-1:0] r_h_count;
    logic                  r_f_found;
    logic [IDX_W-1:0]      r_f_idx;
    logic                  r_v_found;
    logic [IDX_W-1:0]      r_v_idx;
    logic [COUNT_BITS-1:0] r_v_count;
    logic [31:0]           r_v_age;
    logic [31:0]           r_v_key;

    // result
    logic        r_res_vld;
    logic [1:0]  r_res_outcome;
    logic [31:0] r_res_evicted;
    logic [15:0] r_res_count;

    logic                  accept;
    logic                  cap_zero;
    logic [31:0]           cap_eff;
    logic                  room;
    logic [31:0]           rd_age;
    logic                  take_victim;
    logic                  do_free;
    logic                  do_evict;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [COUNT_BITS-1:0] wr_count;
    logic [1:0]            upd_outcome;
    logic [31:0]           count_wide;

    assign accept   = i_start && (r_state == lfu_pkg::S_IDLE);
    assign cap_zero = (r_cap == '0);
    assign cap_eff  = (32'(r_cap) > 32'(ENTRIES)) ? 32'(ENTRIES) : 32'(r_cap);
    assign room     = 32'(r_occupied) < cap_eff;

    // shared compare unit
    assign rd_age      = r_clock - r_rd_stamp;
    assign take_victim = !r_v_found || (r_rd_count < r_v_count) ||
                         ((r_rd_count == r_v_count) && (rd_age > r_v_age));

    always_comb begin
        do_free     = 1'b0;
        do_evict    = 1'b0;
        wr_en       = 1'b0;
        wr_idx      = r_f_idx;
        wr_count    = COUNT_ONE;
        upd_outcome = lfu_pkg::OUT_IGNORE;
        if (r_h_found) begin
            wr_en       = 1'b1;
            wr_idx      = r_h_idx;
            wr_count    = (r_h_count == COUNT_MAX) ? r_h_count : r_h_count + COUNT_ONE;
            upd_outcome = lfu_pkg::OUT_HIT;
        end else if (room && r_f_found) begin
            do_free     = 1'b1;
        end else if (r_v_found) begin
            do_evict    = 1'b1;
        end else if (r_f_found) begin
            do_free     = 1'b1;
        end
        if (do_free) begin
            wr_en       = 1'b1;
            wr_idx      = r_f_idx;
            upd_outcome = lfu_pkg::OUT_FREE;
        end
        if (do_evict) begin
            wr_en       = 1'b1;
            wr_idx      = r_v_idx;
            upd_outcome = lfu_pkg::OUT_EVICT;
        end
    end

    assign count_wide = 32'(wr_count);

    always_comb begin
        n_state = r_state;
        case (r_state)
            lfu_pkg::S_IDLE: begin
                if (accept && !cap_zero) n_state = lfu_pkg::S_SCAN;
            end
            lfu_pkg::S_SCAN: begin
                if (r_addr == LAST_IDX) n_state = lfu_pkg::S_DRAIN;
            end
            lfu_pkg::S_DRAIN:  n_state = lfu_pkg::S_UPDATE;
            lfu_pkg::S_UPDATE: n_state = lfu_pkg::S_IDLE;
            default:           n_state = lfu_pkg::S_IDLE;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lfu_pkg::S_IDLE;
            r_cap      <= lfu_pkg::CAP_RESET;
            r_valid    <= '0;
            r_occupied <= '0;
            r_clock    <= '0;
            r_rd_vld   <= 1'b0;
            r_res_vld  <= 1'b0;
            r_h_found  <= 1'b0;
            r_f_found  <= 1'b0;
            r_v_found  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= (r_state == lfu_pkg::S_SCAN);
            r_res_vld <= (accept && cap_zero) || (r_state == lfu_pkg::S_UPDATE);
            if (i_cfg_valid && o_cfg_ready) r_cap <= i_cfg_data;
            if (accept) begin
                r_h_found <= 1'b0;
                r_f_found <= 1'b0;
                r_v_found <= 1'b0;
            end else if (r_rd_vld) begin
                if (r_rd_valid) begin
                    if (!r_h_found && (r_rd_key == r_req_key)) r_h_found <= 1'b1;
                    if (take_victim) r_v_found <= 1'b1;
                end else if (!r_f_found) begin
                    r_f_found <= 1'b1;
                end
            end
            if (r_state == lfu_pkg::S_UPDATE) begin
                r_clock <= r_clock + 32'd1;
                if (wr_en) r_valid[wr_idx] <= 1'b1;
                if (do_free) r_occupied <= r_occupied + OCC_W'(1);
            end
        end
    end

    // payload and slot memory
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_key   <= i_req_key;
            r_req_value <= i_req_value;
            r_addr      <= '0;
        end else if (r_state == lfu_pkg::S_SCAN) begin
            r_addr      <= r_addr + IDX_W'(1);
        end
        r_rd_idx   <= r_addr;
        r_rd_valid <= r_valid[r_addr];
        r_rd_key   <= mem_key[r_addr];
        r_rd_count <= mem_count[r_addr];
        r_rd_stamp <= mem_stamp[r_addr];
        if (r_rd_vld) begin
            if (r_rd_valid) begin
                if (!r_h_found && (r_rd_key == r_req_key)) begin
                    r_h_idx   <= r_rd_idx;
                    r_h_count <= r_rd_count;
                end
                if (take_victim) begin
                    r_v_idx   <= r_rd_idx;
                    r_v_count <= r_rd_count;
                    r_v_age   <= rd_age;
                    r_v_key   <= r_rd_key;
                end
            end else if (!r_f_found) begin
                r_f_idx <= r_rd_idx;
            end
        end
        if ((r_state == lfu_pkg::S_UPDATE) && wr_en) begin
            mem_key[wr_idx]   <= r_req_key;
            mem_value[wr_idx] <= r_req_value;
            mem_count[wr_idx] <= wr_count;
            mem_stamp[wr_idx] <= r_clock;
        end
        if (accept && cap_zero) begin
            r_res_outcome <= lfu_pkg::OUT_IGNORE;
            r_res_evicted <= '0;
            r_res_count   <= '0;
        end else if (r_state == lfu_pkg::S_UPDATE) begin
            r_res_outcome <= upd_outcome;
            r_res_evicted <= do_evict ? r_v_key : 32'd0;
            r_res_count   <= wr_en ? count_wide[15:0] : 16'd0;
        end
    end

    assign o_busy         = (r_state != lfu_pkg::S_IDLE);
    // capacity only changes between puts
    assign o_cfg_ready    = (r_state == lfu_pkg::S_IDLE) && !i_start;
    assign o_result_valid = r_res_vld;
    assign o_outcome      = r_res_outcome;
    assign o_evicted_key  = r_res_evicted;
    assign o_use_count    = r_res_count;

    // checks
    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(r_state) == lfu_pkg::S_UPDATE) ||
                           ($past(accept) && $past(cap_zero)))
        else $error("result strobe without a finished put");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_occupied) <= 32'(ENTRIES))
        else $error("occupancy above slot count");

    a_free_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_outcome == lfu_pkg::OUT_FREE) |->
            r_occupied == $past(r_occupied) + OCC_W'(1))
        else $error("free-slot insert did not raise occupancy");

    a_evict_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_outcome == lfu_pkg::OUT_EVICT) |->
            r_occupied == $past(r_occupied))
        else $error("eviction changed occupancy");

    a_busy_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> $past(r_state) == lfu_pkg::S_UPDATE)
        else $error("busy dropped before write-back");

endmodule
